[src/mie_pkg.sv]
// Package for the modular inverse block: shared constants.
// No dependencies; imported by mie_div, modular_inverse_ext_euclid and the testbench.
package mie_pkg;

    // Default datapath width of the Euclid iteration
    localparam int DEFAULT_WIDTH = 32;

    // Width of the value, modulus and inverse fields on the ports
    localparam int FIELD_W = 32;

endpackage

[src/mie_div.sv]
// Shared division unit: restoring radix-2 divider, one quotient bit per cycle,
// that also accumulates quotient * multiplicand by shift-and-add. Uses mie_pkg.
module mie_div #(
    parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    input  logic [WIDTH-1:0] mcand,
    output logic             done,
    output logic [WIDTH-1:0] remainder,
    output logic [WIDTH-1:0] product
);
    import mie_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    // divisor and mcand are held steady by the sequencer for the whole division
    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] prod_reg, prod_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;
    logic [WIDTH-1:0] rem_step;
    logic [WIDTH-1:0] prod_step;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        rem_step  = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        prod_step = {prod_reg[WIDTH-2:0], 1'b0} + (ge ? mcand : '0);
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CW'(WIDTH);
            dvd_next    = dividend;
            rem_next    = '0;
            prod_next   = '0;
        end
        else if (active_reg)
        begin
            dvd_next  = {dvd_reg[WIDTH-2:0], 1'b0};
            rem_next  = rem_step;
            prod_next = prod_step;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign product   = prod_reg;

endmodule

[src/modular_inverse_ext_euclid.sv]
// Top level of the modular inverse block: extended Euclid sequencer around
// the shared divider mie_div. Uses mie_pkg.
//
// Usage:
//   Command channel: drive value and modulus and raise start; the beat is
//   taken at a rising edge with start high and busy low. busy stays high
//   until the result has been formed.
//   Result channel: done is high for exactly one cycle, and inverse and
//   exists are valid in that cycle. The receiver cannot stall; capture the
//   beat when done is seen.
//   Sequence: each Euclid round runs a check state, WIDTH divider steps in
//   S_DIV and a fold of the quotient back into the cofactors; a final check
//   forms the result. Rounds grow to about 46 at 32 bits, and a zero
//   modulus goes straight from the first check to the result.
//   Throughput: one item at a time, set by the bit-serial divider which
//   handles one quotient bit per cycle. A new start may be issued in the
//   same cycle that done is high.
//   Reset: rst_n is asynchronous, active low; it returns the sequencer to
//   idle and clears done and busy. No item in flight survives reset.
//   inverse is 0 and exists is 0 whenever the final remainder is not one.
module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mie_pkg::FIELD_W-1:0] value,
    input  logic [mie_pkg::FIELD_W-1:0] modulus,
    output logic                       done,
    output logic [mie_pkg::FIELD_W-1:0] inverse,
    output logic                       exists
);
    import mie_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_SPARE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Euclid registers: remainder pair, cofactor pair, parity and modulus
    logic [WIDTH-1:0] a_rem_reg, a_rem_next;
    logic [WIDTH-1:0] b_rem_reg, b_rem_next;
    logic [WIDTH-1:0] a_cof_reg, a_cof_next;
    logic [WIDTH-1:0] b_cof_reg, b_cof_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic             odd_reg, odd_next;

    logic               done_reg, done_next;
    logic               exists_reg, exists_next;
    logic [FIELD_W-1:0] inverse_reg, inverse_next;

    logic               div_start;
    logic               div_done;
    logic [WIDTH-1:0]   div_rem;
    logic [WIDTH-1:0]   div_prod;

    logic [WIDTH+FIELD_W-1:0] value_ext;
    logic [WIDTH+FIELD_W-1:0] modulus_ext;
    logic [WIDTH-1:0]         inv_w;
    logic [WIDTH+FIELD_W-1:0] inv_ext;
    logic                     rem_is_one;

    // Truncate or zero-extend the port fields to the datapath width
    assign value_ext   = {{WIDTH{1'b0}}, value};
    assign modulus_ext = {{WIDTH{1'b0}}, modulus};

    // Final selection: cofactor for an even round count, modulus minus it for odd
    assign rem_is_one = (a_rem_reg == WIDTH'(1));
    assign inv_w      = odd_reg ? (mod_reg - a_cof_reg) : a_cof_reg;
    assign inv_ext    = {{FIELD_W{1'b0}}, inv_w};

    mie_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_rem_reg),
        .divisor   (b_rem_reg),
        .mcand     (b_cof_reg),
        .done      (div_done),
        .remainder (div_rem),
        .product   (div_prod)
    );

    always_comb
    begin
        state_next   = state_reg;
        a_rem_next   = a_rem_reg;
        b_rem_next   = b_rem_reg;
        a_cof_next   = a_cof_reg;
        b_cof_next   = b_cof_reg;
        mod_next     = mod_reg;
        odd_next     = odd_reg;
        done_next    = 1'b0;
        exists_next  = exists_reg;
        inverse_next = inverse_reg;
        div_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_rem_next = value_ext[WIDTH-1:0];
                    b_rem_next = modulus_ext[WIDTH-1:0];
                    mod_next   = modulus_ext[WIDTH-1:0];
                    a_cof_next = WIDTH'(1);
                    b_cof_next = '0;
                    odd_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (b_rem_reg != '0)
                begin
                    // launch one division round on the shared unit
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    // remainder sequence ended: form and post the result beat
                    done_next    = 1'b1;
                    exists_next  = rem_is_one;
                    inverse_next = rem_is_one ? inv_ext[FIELD_W-1:0] : '0;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // advance the pairs: new cofactor = a_cof + quotient * b_cof
                    a_rem_next = b_rem_reg;
                    b_rem_next = div_rem;
                    a_cof_next = b_cof_reg;
                    b_cof_next = a_cof_reg + div_prod;
                    odd_next   = ~odd_reg;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rem_reg   <= a_rem_next;
        b_rem_reg   <= b_rem_next;
        a_cof_reg   <= a_cof_next;
        b_cof_reg   <= b_cof_next;
        mod_reg     <= mod_next;
        odd_reg     <= odd_next;
        exists_reg  <= exists_next;
        inverse_reg <= inverse_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign exists  = exists_reg;
    assign inverse = inverse_reg;

`ifndef ASSERT_OFF
    // The result beat is posted only as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat posted while busy");

    // No inverse is reported when the final remainder was not one
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !exists) |-> (inverse == '0))
        else $error("nonzero inverse without exists");

    // The divider only reports completion while a round is pending
    a_div_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside a division round");

    // An accepted command beat always starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not raise busy");
`endif

endmodule

[sim/tb_modular_inverse_ext_euclid.sv]
`timescale 1ns / 1ps
// Testbench for modular_inverse_ext_euclid: random and directed operand beats,
// with every result checked against an extended Euclid predictor in the bench.
// Depends on mie_pkg and the modular_inverse_ext_euclid RTL only.
module tb_modular_inverse_ext_euclid;

    import mie_pkg::*;

    typedef logic [FIELD_W-1:0] word_t;

    // One command beat waiting to go out; drain holds it back until the
    // block has returned every result it owes.
    typedef struct {
        word_t value;
        word_t modulus;
        bit    drain;
    } operand_t;

    // Predicted result, with the operands kept for the mismatch report.
    typedef struct {
        word_t value;
        word_t modulus;
        word_t inverse;
        logic  exists;
    } inverse_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    word_t value = '0;
    word_t modulus = '0;
    logic  busy;
    logic  done;
    word_t inverse;
    logic  exists;

    operand_t operand_q[$];
    inverse_t inverse_due[$];

    bit holding = 1'b0;      // start is high with a beat on the ports
    bit beat_taken = 1'b0;   // the block took the beat at the last rising edge
    int gap_left = 0;
    int calm_left = 0;
    int err_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int inverses_found = 0;
    int no_inverse = 0;

    modular_inverse_ext_euclid dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .value   (value),
        .modulus (modulus),
        .done    (done),
        .inverse (inverse),
        .exists  (exists)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Extended Euclid with one unsigned cofactor and a round parity. The
    // remainders start at (value, modulus); every round swaps in the new
    // remainder and folds the quotient into the cofactor pair. A final
    // remainder of one means an inverse exists: take the cofactor on an even
    // round count, or the modulus minus the cofactor on an odd one.
    function automatic inverse_t mod_inverse(input word_t v, input word_t m);
        logic [63:0] a_rem;
        logic [63:0] b_rem;
        logic [63:0] a_cof;
        logic [63:0] b_cof;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] cof;
        bit          odd;
        inverse_t    r;
        a_rem = {32'd0, v};
        b_rem = {32'd0, m};
        a_cof = 64'd1;
        b_cof = 64'd0;
        odd = 1'b0;
        while (b_rem != 64'd0)
        begin
            quo = a_rem / b_rem;
            rem = a_rem % b_rem;
            cof = (a_cof + quo * b_cof) & 64'h0000_0000_FFFF_FFFF;
            a_cof = b_cof;
            b_cof = cof;
            a_rem = b_rem;
            b_rem = rem;
            odd = ~odd;
        end
        r.value = v;
        r.modulus = m;
        r.inverse = '0;
        r.exists = 1'b0;
        if (a_rem == 64'd1)
        begin
            r.exists = 1'b1;
            r.inverse = odd ? word_t'(m - a_cof[31:0]) : a_cof[31:0];
        end
        return r;
    endfunction

    // Count every failure and report it with its time.
    task automatic flag_error(input string msg);
        err_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic add_beat(input word_t v, input word_t m, input bit drain);
        operand_t op;
        op.value = v;
        op.modulus = m;
        op.drain = drain;
        operand_q.push_back(op);
    endtask

    // Idle time after a beat: mostly none or short, now and then long, and
    // occasional calm stretches where beats follow back to back.
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Driver: change inputs only at the falling edge. Hold a beat until the
    // monitor reports it taken, then sit out the gap and present the next.
    // Put junk on the operand ports while start is low; the block must
    // ignore it.
    always @(negedge clk)
    begin
        operand_t op;
        if (!rst_n)
        begin
            start <= 1'b0;
            holding = 1'b0;
            beat_taken = 1'b0;
        end
        else
        begin
            if (beat_taken)
            begin
                beat_taken = 1'b0;
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (operand_q.size() != 0)
                begin
                    // Drain beats wait until the block has gone quiet
                    if (!(operand_q[0].drain && (inverse_due.size() != 0 || busy)))
                    begin
                        op = operand_q.pop_front();
                        holding = 1'b1;
                        gap_left = pick_gap();
                    end
                end
            end
            if (holding)
            begin
                if (!$isunknown(op.value))
                begin
                    value <= op.value;
                    modulus <= op.modulus;
                end
            end
            else
            begin
                value <= $urandom;
                modulus <= $urandom;
            end
            start <= holding;
        end
    end

    // Monitor: sample both channels at the rising edge. Check a result beat
    // against the oldest prediction first, then record any command beat the
    // block takes at this same edge.
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (inverse_due.size() == 0)
                    flag_error($sformatf("result with nothing pending: inverse %h exists %b",
                                         inverse, exists));
                else
                begin
                    want = inverse_due.pop_front();
                    if (inverse !== want.inverse)
                        flag_error($sformatf(
                            "inverse of %h mod %h: expected %h, got %h",
                            want.value, want.modulus, want.inverse, inverse));
                    if (exists !== want.exists)
                        flag_error($sformatf(
                            "exists for %h mod %h: expected %b, got %b",
                            want.value, want.modulus, want.exists, exists));
                    if (want.exists)
                        inverses_found++;
                    else
                        no_inverse++;
                end
            end
            if (start && !busy)
            begin
                inverse_due.push_back(mod_inverse(value, modulus));
                beat_taken = 1'b1;
                beats_sent++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] fib_seq[0:48];
        logic [63:0] mask;
        word_t       v;
        word_t       m;
        int          sel;
        int          k;

        fib_seq[0] = 64'd0;
        fib_seq[1] = 64'd1;
        for (int i = 2; i <= 48; i++)
            fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];

        // Directed: zero modulus, modulus of one, zero value, value above
        // the modulus, no-inverse pairs, field extremes and the longest
        // Fibonacci remainder chain that fits the field.
        add_beat(32'd0, 32'd0, 1'b0);
        add_beat(32'd1, 32'd0, 1'b0);
        add_beat(32'd5, 32'd0, 1'b0);
        add_beat(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_beat(32'd0, 32'd1, 1'b0);
        add_beat(32'd1, 32'd1, 1'b0);
        add_beat(32'd7, 32'd1, 1'b0);
        add_beat(32'hFFFF_FFFF, 32'd1, 1'b0);
        add_beat(32'd0, 32'd7, 1'b0);
        add_beat(32'd3, 32'd7, 1'b0);
        add_beat(32'd7, 32'd3, 1'b0);
        add_beat(32'd2, 32'd4, 1'b0);
        add_beat(32'd5, 32'd5, 1'b0);
        add_beat(32'd1, 32'hFFFF_FFFF, 1'b0);
        add_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        add_beat(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        add_beat(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_beat(32'hDEAD_BEEF, 32'hFFFF_FFFB, 1'b0);
        add_beat(fib_seq[46][31:0], fib_seq[47][31:0], 1'b1);
        add_beat(fib_seq[47][31:0], fib_seq[46][31:0], 1'b0);
        add_beat(32'h5555_5555, 32'hAAAA_AAAB, 1'b0);

        // Random: mostly full-width pairs, plus small-number pairs,
        // random bit widths, edge mixes, odd moduli and long Fibonacci chains.
        for (int n = 0; n < 400; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                v = $urandom;
                m = $urandom;
            end
            else if (sel < 60)
            begin
                v = $urandom_range(0, 255);
                m = $urandom_range(0, 255);
            end
            else if (sel < 72)
            begin
                mask = (64'd1 << $urandom_range(1, 32)) - 64'd1;
                v = $urandom & mask[31:0];
                mask = (64'd1 << $urandom_range(1, 32)) - 64'd1;
                m = $urandom & mask[31:0];
            end
            else if (sel < 84)
            begin
                case ($urandom_range(0, 4))
                    0: m = 32'd0;
                    1: m = 32'd1;
                    2: m = 32'd2;
                    3: m = 32'hFFFF_FFFF;
                    default: m = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'hFFFF_FFFF;
                    3: v = m;
                    4: v = m - 32'd1;
                    default: v = m + 32'd1;
                endcase
            end
            else if (sel < 94)
            begin
                v = $urandom;
                m = $urandom | 32'd1;
            end
            else
            begin
                k = $urandom_range(20, 46);
                if ($urandom_range(0, 1) == 0)
                begin
                    v = fib_seq[k][31:0];
                    m = fib_seq[k+1][31:0];
                end
                else
                begin
                    v = fib_seq[k+1][31:0];
                    m = fib_seq[k][31:0];
                end
            end
            add_beat(v, m, (n % 64) == 0);
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to go out, then for every result, then
        // watch a while longer for stray result beats.
        while (operand_q.size() != 0 || holding)
            @(posedge clk);
        while (inverse_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d operand beats and checked %0d results", beats_sent, results_seen);
        $display("%0d had an inverse, %0d had none", inverses_found, no_inverse);
        if (err_count == 0)
            $display("tb_modular_inverse_ext_euclid OK");
        else
            $display("tb_modular_inverse_ext_euclid NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(40_000_000);
        $display("Timed out with %0d results still pending", inverse_due.size());
        $display("tb_modular_inverse_ext_euclid NOT OK");
        $finish;
    end

endmodule
